// ===== rtl/tdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tdq_pkg;

   // field widths
   localparam int TAG_W   = 16;
   localparam int DUR_W   = 24;
   localparam int CLASS_W = 2;
   localparam int KIND_W  = 2;
   localparam int OCC_W   = 9;
   localparam int CAP_W   = 8;
   localparam int ENTRY_W = CLASS_W + DUR_W + TAG_W;

   // defaults for top level parameters
   localparam int QUEUE_DEPTH_DEF   = 256;
   localparam int OP_FIFO_DEPTH_DEF = 4;

   // capacity register reset value
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 8'd200;

   // watermarks: high at count*5 >= cap*4, low at count*4 < cap
   localparam int HI_CNT_MUL = 5;
   localparam int HI_CAP_MUL = 4;
   localparam int LO_CNT_MUL = 4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DROP   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DEPART = 2'd2;
   localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd3;

   // packet classes
   localparam logic [CLASS_W-1:0] CLASS_DATA   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_ALARM  = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_RELIEF = 2'd2;

   // operations from front to back
   localparam logic [1:0] OP_DROP   = 2'd0;
   localparam logic [1:0] OP_IDLE   = 2'd1;
   localparam logic [1:0] OP_DEPART = 2'd2;
   localparam logic [1:0] OP_ARRIVE = 2'd3;

   typedef struct packed {
      logic [1:0]         op_kind;
      logic [CLASS_W-1:0] fb_class;  // feedback packet to insert, data means none
      logic               fb_plain;  // queue was empty, feedback goes to the tail
      logic               do_pop;    // server idle, arrival departs at once
      logic [TAG_W-1:0]   tag;
      logic [DUR_W-1:0]   dur;
      logic [OCC_W-1:0]   occ_a;     // occupancy for the first result
      logic [OCC_W-1:0]   occ_b;     // occupancy for a departure result
   } op_type;

endpackage

`default_nettype wire

// ===== rtl/tdq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdq_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tdq_op_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdq_op_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tdq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdq_front
   import tdq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_en,
   input  wire logic [CAP_W-1:0] csr_write_data,
   input  wire logic             req_push,
   input  wire logic             req_cmd,
   input  wire logic [TAG_W-1:0] req_packet_tag,
   input  wire logic [DUR_W-1:0] req_packet_duration,
   input  wire logic             op_full,
   output logic                  op_push,
   output op_type                op_data
);

   localparam int DEPTH_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CW      = ((DEPTH_W > OCC_W) ? DEPTH_W : OCC_W) + 1;

   logic [CAP_W-1:0]   capacity_ff, capacity_in;
   logic [OCC_W-1:0]   count_ff, count_in;
   logic               alarm_ff, alarm_in;
   logic               busy_ff, busy_in;

   logic               hi_mark, lo_mark, below_cap, over_store, drop;
   logic [CLASS_W-1:0] fb;
   logic [CW-1:0]      need;
   logic [OCC_W-1:0]   count_a, count_b;

   // watermark tests and the drop decision
   always_comb begin
      hi_mark   = (12'(count_ff) * 12'(HI_CNT_MUL)) >= (12'(capacity_ff) * 12'(HI_CAP_MUL));
      lo_mark   = (11'(count_ff) * 11'(LO_CNT_MUL)) < 11'(capacity_ff);
      below_cap = count_ff < OCC_W'(capacity_ff);
      fb        = CLASS_DATA;
      if (below_cap) begin
         if (!alarm_ff && hi_mark) begin
            fb = CLASS_ALARM;
         end else if (alarm_ff && lo_mark) begin
            fb = CLASS_RELIEF;
         end
      end
      need       = (fb != CLASS_DATA) ? CW'(2) : CW'(1);
      over_store = (CW'(count_ff) + need) > CW'(QUEUE_DEPTH);
      drop       = !below_cap || over_store;
      count_a    = count_ff + ((fb != CLASS_DATA) ? OCC_W'(2) : OCC_W'(1));
      count_b    = count_a - 1'b1;
   end

   // classify the item and update the counters
   always_comb begin
      op_push     = req_push && !op_full;
      capacity_in = csr_write_en ? csr_write_data : capacity_ff;
      count_in    = count_ff;
      alarm_in    = alarm_ff;
      busy_in     = busy_ff;

      op_data          = '0;
      op_data.tag      = req_packet_tag;
      op_data.dur      = req_packet_duration;
      op_data.occ_a    = count_ff;
      op_data.occ_b    = count_ff;
      op_data.op_kind  = OP_DROP;

      if (req_cmd) begin
         // service done tick
         if (count_ff != '0) begin
            op_data.op_kind = OP_DEPART;
            op_data.occ_a   = count_ff - 1'b1;
            op_data.occ_b   = count_ff - 1'b1;
            count_in        = count_ff - 1'b1;
            busy_in         = 1'b1;
         end else begin
            op_data.op_kind = OP_IDLE;
            busy_in         = 1'b0;
         end
      end else if (!drop) begin
         // arrival that fits
         op_data.op_kind  = OP_ARRIVE;
         op_data.fb_class = fb;
         op_data.fb_plain = (count_ff == '0);
         op_data.do_pop   = !busy_ff;
         op_data.occ_a    = count_a;
         op_data.occ_b    = count_b;
         if (fb != CLASS_DATA) begin
            alarm_in = (fb == CLASS_ALARM);
         end
         count_in = busy_ff ? count_a : count_b;
         busy_in  = 1'b1;
      end

      if (!op_push) begin
         count_in = count_ff;
         alarm_in = alarm_ff;
         busy_in  = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         count_ff    <= '0;
         alarm_ff    <= 1'b0;
         busy_ff     <= 1'b0;
      end else begin
         capacity_ff <= capacity_in;
         count_ff    <= count_in;
         alarm_ff    <= alarm_in;
         busy_ff     <= busy_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tdq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdq_back
   import tdq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               op_empty,
   input  op_type                  op_data,
   output logic                    op_pop,
   input  wire logic               rsp_pop,
   output logic                    rsp_empty,
   output logic [KIND_W-1:0]       rsp_result_kind,
   output logic [TAG_W-1:0]        rsp_out_tag,
   output logic [DUR_W-1:0]        rsp_out_duration,
   output logic [CLASS_W-1:0]      rsp_out_class,
   output logic [OCC_W-1:0]        rsp_occupancy,
   output logic                    rsp_last
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] B_FETCH  = 2'd0;
   localparam logic [1:0] B_DATA   = 2'd1;
   localparam logic [1:0] B_READ   = 2'd2;
   localparam logic [1:0] B_DEPART = 2'd3;

   logic [1:0]         state_ff, state_in;
   op_type             op_ff, op_in;
   logic [AW-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [AW-1:0]      head_inc, head_dec, tail_inc;

   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;

   logic               out_free, emit;
   logic [KIND_W-1:0]  emit_kind;
   logic [ENTRY_W-1:0] emit_entry;
   logic [OCC_W-1:0]   emit_occ;
   logic               emit_last;

   logic               out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]  out_kind_ff;
   logic [ENTRY_W-1:0] out_entry_ff;
   logic [OCC_W-1:0]   out_occ_ff;
   logic               out_last_ff;

   tdq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   // ring pointer steps
   assign head_inc = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? AW'(QUEUE_DEPTH - 1) : head_ff - 1'b1;
   assign tail_inc = (tail_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   assign out_free = !out_valid_ff || rsp_pop;

   // store engine: one queue operation at a time, each finished before the next is fetched
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      op_pop     = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = tail_ff;
      wr_data    = {CLASS_DATA, op_ff.dur, op_ff.tag};
      rd_en      = 1'b0;
      emit       = 1'b0;
      emit_kind  = KIND_ACCEPT;
      emit_entry = '0;
      emit_occ   = op_ff.occ_a;
      emit_last  = 1'b1;

      case (state_ff)
         B_FETCH: begin
            if (!op_empty) begin
               case (op_data.op_kind)
                  OP_DROP, OP_IDLE: begin
                     if (out_free) begin
                        op_pop    = 1'b1;
                        emit      = 1'b1;
                        emit_kind = (op_data.op_kind == OP_DROP) ? KIND_DROP : KIND_IDLE;
                        emit_occ  = op_data.occ_a;
                     end
                  end
                  OP_DEPART: begin
                     op_pop   = 1'b1;
                     op_in    = op_data;
                     rd_en    = 1'b1;
                     head_in  = head_inc;
                     state_in = B_DEPART;
                  end
                  OP_ARRIVE: begin
                     op_pop   = 1'b1;
                     op_in    = op_data;
                     state_in = B_DATA;
                     // feedback packet goes in first
                     if (op_data.fb_class != CLASS_DATA) begin
                        wr_en   = 1'b1;
                        wr_data = {op_data.fb_class, {DUR_W{1'b0}}, {TAG_W{1'b0}}};
                        if (op_data.fb_plain) begin
                           wr_addr = tail_ff;
                           tail_in = tail_inc;
                        end else begin
                           wr_addr = head_dec;
                           head_in = head_dec;
                        end
                     end
                  end
                  default: begin
                     op_pop = 1'b1;
                  end
               endcase
            end
         end
         B_DATA: begin
            // append the arrival and report it
            if (out_free) begin
               wr_en     = 1'b1;
               wr_addr   = tail_ff;
               tail_in   = tail_inc;
               emit      = 1'b1;
               emit_kind = KIND_ACCEPT;
               emit_occ  = op_ff.occ_a;
               emit_last = !op_ff.do_pop;
               state_in  = op_ff.do_pop ? B_READ : B_FETCH;
            end
         end
         B_READ: begin
            rd_en    = 1'b1;
            head_in  = head_inc;
            state_in = B_DEPART;
         end
         B_DEPART: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_kind  = KIND_DEPART;
               emit_entry = rd_data;
               emit_occ   = op_ff.occ_b;
               state_in   = B_FETCH;
            end
         end
         default: begin
            state_in = B_FETCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_FETCH;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   // result register
   assign out_valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_kind_ff  <= emit_kind;
         out_entry_ff <= emit_entry;
         out_occ_ff   <= emit_occ;
         out_last_ff  <= emit_last;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_result_kind  = out_kind_ff;
   assign rsp_out_tag      = out_entry_ff[TAG_W-1:0];
   assign rsp_out_duration = out_entry_ff[TAG_W +: DUR_W];
   assign rsp_out_class    = out_entry_ff[TAG_W + DUR_W +: CLASS_W];
   assign rsp_occupancy    = out_occ_ff;
   assign rsp_last         = out_last_ff;

endmodule

`default_nettype wire

// ===== rtl/tail_drop_queue_with_watermark_feedback_top.sv =====
// Drop-tail packet queue with alarm/relief congestion feedback.
// Input channel: req_push with req_cmd, req_packet_tag, req_packet_duration;
// a beat is taken when req_push is high and req_full low. cmd 0 is a packet
// arrival, cmd 1 a service-done tick.
// Result channel: a beat waits on the rsp_ ports while rsp_empty is low and
// leaves when rsp_pop is high. A tick gives one beat, an arrival one or two;
// rsp_last marks the final beat of an item.
// csr_write_en / csr_write_data load the drop threshold (capacity) register;
// write it only while the block is idle.
// The front classifies each item in the cycle it is taken and queues one
// operation (op queue of OP_FIFO_DEPTH entries). The back store engine runs
// one queue operation at a time on a single-port-write, registered-read RAM:
// a drop or idle result is emitted in B_FETCH, a tick that departs passes
// B_FETCH and B_DEPART, a stored arrival B_FETCH and B_DATA, and an arrival
// that departs at once B_FETCH, B_DATA, B_READ and B_DEPART. Each first beat
// passes the op queue and the result register on its way to the rsp ports.
// When rsp_pop stays low the result register holds, the back engine stops,
// the op queue fills and req_full rises; nothing is lost.
// Reset (synchronous, active high) empties the queue, clears alarm and busy
// state and sets capacity to 200. Queue RAM content is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module tail_drop_queue_with_watermark_feedback_top
   import tdq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
   parameter int OP_FIFO_DEPTH = OP_FIFO_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_en,
   input  wire logic [CAP_W-1:0]   csr_write_data,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic               req_cmd,
   input  wire logic [TAG_W-1:0]   req_packet_tag,
   input  wire logic [DUR_W-1:0]   req_packet_duration,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [KIND_W-1:0]       rsp_result_kind,
   output logic [TAG_W-1:0]        rsp_out_tag,
   output logic [DUR_W-1:0]        rsp_out_duration,
   output logic [CLASS_W-1:0]      rsp_out_class,
   output logic [OCC_W-1:0]        rsp_occupancy,
   output logic                    rsp_last
);

   localparam int OP_W = $bits(op_type);

   logic   op_full, op_push, op_empty, op_pop;
   op_type front_op, back_op;
   logic [OP_W-1:0] back_op_bits;

   tdq_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_write_data      (csr_write_data),
      .req_push            (req_push),
      .req_cmd             (req_cmd),
      .req_packet_tag      (req_packet_tag),
      .req_packet_duration (req_packet_duration),
      .op_full             (op_full),
      .op_push             (op_push),
      .op_data             (front_op)
   );

   tdq_op_fifo #(
      .WIDTH (OP_W),
      .DEPTH (OP_FIFO_DEPTH)
   ) u_op_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (front_op),
      .full      (op_full),
      .pop       (op_pop),
      .pop_data  (back_op_bits),
      .empty     (op_empty)
   );

   assign back_op  = op_type'(back_op_bits);
   assign req_full = op_full;

   tdq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .op_empty         (op_empty),
      .op_data          (back_op),
      .op_pop           (op_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_duration (rsp_out_duration),
      .rsp_out_class    (rsp_out_class),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_last         (rsp_last)
   );

   // no result waits right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // only departures carry a packet
   a_nondepart_blank: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind != KIND_DEPART) |->
      (rsp_out_tag == '0 && rsp_out_duration == '0 && rsp_out_class == CLASS_DATA))
      else $error("non-departure beat carries packet fields");

   // feedback packets have no tag and no duration
   a_feedback_blank: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_out_class != CLASS_DATA) |->
      (rsp_out_tag == '0 && rsp_out_duration == '0 && rsp_result_kind == KIND_DEPART))
      else $error("feedback packet with payload");

   // server goes idle only on an empty queue
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind == KIND_IDLE) |-> (rsp_occupancy == '0))
      else $error("idle result with nonzero occupancy");

endmodule

`default_nettype wire

// ===== tb/tail_drop_queue_with_watermark_feedback_top_tb.sv =====
`timescale 1ns / 1ps

import tdq_pkg::*;

// one result beat as it leaves the block
typedef struct packed {
   logic [KIND_W-1:0]  kind;
   logic [TAG_W-1:0]   tag;
   logic [DUR_W-1:0]   dur;
   logic [CLASS_W-1:0] cls;
   logic [OCC_W-1:0]   occ;
   logic               last;
} result_beat_type;

// shadow copy of the packet queue, its server and its alarm state
class packet_queue_shadow;
   logic [ENTRY_W-1:0] slots [QUEUE_DEPTH_DEF];
   int unsigned        head_ptr;
   int unsigned        tail_ptr;
   int unsigned        fill;
   int unsigned        cap;
   bit                 alarm_up;
   bit                 serving;
   result_beat_type    pending_results[$];
   int unsigned        mismatches;
   int unsigned        items;
   int unsigned        beats;
   int unsigned        drops;
   int unsigned        alarms;
   int unsigned        reliefs;
   int unsigned        idles;

   function new();
      head_ptr   = 0;
      tail_ptr   = 0;
      fill       = 0;
      cap        = CAPACITY_RESET;
      alarm_up   = 1'b0;
      serving    = 1'b0;
      mismatches = 0;
      items      = 0;
      beats      = 0;
      drops      = 0;
      alarms     = 0;
      reliefs    = 0;
      idles      = 0;
   endfunction

   task flag_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   // beat fields come from the entry, occupancy from the current fill
   function void queue_result(input logic [KIND_W-1:0] kind,
                              input logic [ENTRY_W-1:0] entry, input logic last);
      result_beat_type b;
      b.kind = kind;
      b.tag  = entry[TAG_W-1:0];
      b.dur  = entry[TAG_W +: DUR_W];
      b.cls  = entry[TAG_W+DUR_W +: CLASS_W];
      b.occ  = OCC_W'(fill);
      b.last = last;
      pending_results.push_back(b);
   endfunction

   function void append_entry(input logic [ENTRY_W-1:0] entry);
      slots[tail_ptr] = entry;
      tail_ptr = (tail_ptr + 1) % QUEUE_DEPTH_DEF;
      fill++;
   endfunction

   function logic [ENTRY_W-1:0] take_head();
      logic [ENTRY_W-1:0] entry;
      entry = slots[head_ptr];
      head_ptr = (head_ptr + 1) % QUEUE_DEPTH_DEF;
      fill--;
      return entry;
   endfunction

   // work out the beats caused by one accepted item
   function void admit_item(input logic cmd, input logic [TAG_W-1:0] tag,
                            input logic [DUR_W-1:0] dur);
      logic [CLASS_W-1:0] fb;
      logic [ENTRY_W-1:0] entry;
      int unsigned        need;
      items++;
      // service tick: next packet departs or the server goes idle
      if (cmd) begin
         if (fill != 0) begin
            entry = take_head();
            serving = 1'b1;
            queue_result(KIND_DEPART, entry, 1'b1);
         end else begin
            serving = 1'b0;
            idles++;
            queue_result(KIND_IDLE, '0, 1'b1);
         end
         return;
      end
      // watermark check on the occupancy the arrival sees
      fb = CLASS_DATA;
      if (fill < cap) begin
         if (!alarm_up && fill * HI_CNT_MUL >= cap * HI_CAP_MUL) fb = CLASS_ALARM;
         else if (alarm_up && fill * LO_CNT_MUL < cap) fb = CLASS_RELIEF;
      end
      need = (fb != CLASS_DATA) ? 2 : 1;
      // tail drop, also when the store cannot take arrival plus feedback
      if (fill >= cap || fill + need > QUEUE_DEPTH_DEF) begin
         drops++;
         queue_result(KIND_DROP, '0, 1'b1);
         return;
      end
      // feedback goes in front, or is a plain insert into an empty queue
      if (fb != CLASS_DATA) begin
         entry = {fb, {DUR_W{1'b0}}, {TAG_W{1'b0}}};
         if (fill == 0) append_entry(entry);
         else begin
            head_ptr = (head_ptr + QUEUE_DEPTH_DEF - 1) % QUEUE_DEPTH_DEF;
            slots[head_ptr] = entry;
            fill++;
         end
         alarm_up = (fb == CLASS_ALARM);
         if (alarm_up) alarms++;
         else reliefs++;
      end
      append_entry({CLASS_DATA, dur, tag});
      // an idle server takes the head at once
      if (serving) begin
         queue_result(KIND_ACCEPT, '0, 1'b1);
      end else begin
         queue_result(KIND_ACCEPT, '0, 1'b0);
         entry = take_head();
         serving = 1'b1;
         queue_result(KIND_DEPART, entry, 1'b1);
      end
   endfunction

   // compare one beat with the oldest one waiting
   task check_result(input result_beat_type got);
      result_beat_type want;
      if (pending_results.size() == 0) begin
         flag_mismatch($sformatf("beat with nothing waiting: kind %0d tag %h",
                                 got.kind, got.tag));
         return;
      end
      want = pending_results.pop_front();
      beats++;
      if (got.kind != want.kind)
         flag_mismatch($sformatf("beat %0d kind %0d, want %0d", beats, got.kind, want.kind));
      if (got.tag != want.tag)
         flag_mismatch($sformatf("beat %0d tag %h, want %h", beats, got.tag, want.tag));
      if (got.dur != want.dur)
         flag_mismatch($sformatf("beat %0d duration %h, want %h", beats, got.dur, want.dur));
      if (got.cls != want.cls)
         flag_mismatch($sformatf("beat %0d class %0d, want %0d", beats, got.cls, want.cls));
      if (got.occ != want.occ)
         flag_mismatch($sformatf("beat %0d occupancy %0d, want %0d", beats, got.occ, want.occ));
      if (got.last != want.last)
         flag_mismatch($sformatf("beat %0d last %0d, want %0d", beats, got.last, want.last));
   endtask
endclass

module tail_drop_queue_with_watermark_feedback_top_tb;

   localparam int RUN_LIMIT     = 200000;
   localparam int SETTLE_CYCLES = 8;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_en;
   logic [CAP_W-1:0]   csr_write_data;
   logic               req_push;
   logic               req_full;
   logic               req_cmd;
   logic [TAG_W-1:0]   req_packet_tag;
   logic [DUR_W-1:0]   req_packet_duration;
   logic               rsp_empty;
   logic               rsp_pop;
   logic [KIND_W-1:0]  rsp_result_kind;
   logic [TAG_W-1:0]   rsp_out_tag;
   logic [DUR_W-1:0]   rsp_out_duration;
   logic [CLASS_W-1:0] rsp_out_class;
   logic [OCC_W-1:0]   rsp_occupancy;
   logic               rsp_last;

   packet_queue_shadow shadow;
   int unsigned        cycle_count = 0;
   int unsigned        hold_request = 0;
   bit                 steady = 1'b0;

   tail_drop_queue_with_watermark_feedback_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_write_data      (csr_write_data),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_cmd             (req_cmd),
      .req_packet_tag      (req_packet_tag),
      .req_packet_duration (req_packet_duration),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_out_tag         (rsp_out_tag),
      .rsp_out_duration    (rsp_out_duration),
      .rsp_out_class       (rsp_out_class),
      .rsp_occupancy       (rsp_occupancy),
      .rsp_last            (rsp_last)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("tail_drop_queue_with_watermark_feedback_top_tb failed");
         $finish;
      end
   end

   // result side: check each popped beat, random stalls and long holds
   initial begin : result_side
      int unsigned     hold_left;
      result_beat_type got;
      hold_left = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got = {rsp_result_kind, rsp_out_tag, rsp_out_duration, rsp_out_class,
                   rsp_occupancy, rsp_last};
            shadow.check_result(got);
         end
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (reset) rsp_pop <= 1'b0;
         else if (hold_left != 0) begin
            rsp_pop <= 1'b0;
            hold_left--;
         end else rsp_pop <= steady || $urandom_range(0, 99) >= 15;
      end
   end

   // offer one item and wait until the block takes the beat
   task automatic offer_item(input logic cmd, input logic [TAG_W-1:0] tag,
                             input logic [DUR_W-1:0] dur);
      if (!steady && $urandom_range(0, 99) < 15) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_push            <= 1'b1;
      req_cmd             <= cmd;
      req_packet_tag      <= tag;
      req_packet_duration <= dur;
      do @(posedge clock); while (req_full);
      shadow.admit_item(cmd, tag, dur);
   endtask

   // stop offering until every beat is back, then let the engine settle
   task automatic drain_outstanding();
      req_push <= 1'b0;
      while (shadow.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      drain_outstanding();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      shadow.cap = value;
   endtask

   // bursts lean toward the next watermark so the queue swings between them
   task automatic random_items(input int n_items);
      int burst_left;
      int arrive_pct;
      burst_left = 0;
      arrive_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(6, 30);
            if ($urandom_range(0, 9) < 3) arrive_pct = 10 + 40 * $urandom_range(0, 2);
            else if (shadow.fill >= shadow.cap) arrive_pct = 15;
            else if (shadow.alarm_up) arrive_pct = 25;
            else arrive_pct = 90;
         end
         burst_left--;
         offer_item($urandom_range(0, 99) >= arrive_pct, TAG_W'($urandom_range(0, 16'hFFFF)),
                    DUR_W'($urandom_range(0, 24'hFFFFFF)));
      end
   endtask

   initial begin : stimulus
      logic [CAP_W-1:0] mid_cap;
      shadow = new();
      reset               <= 1'b1;
      csr_write_en        <= 1'b0;
      csr_write_data      <= '0;
      req_push            <= 1'b0;
      req_cmd             <= 1'b0;
      req_packet_tag      <= '0;
      req_packet_duration <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: tick on empty, field extremes, departure, back to idle
      offer_item(1'b1, '0, '0);
      offer_item(1'b0, 16'h0000, 24'h000000);
      offer_item(1'b0, 16'hFFFF, 24'hFFFFFF);
      offer_item(1'b1, '0, '0);
      offer_item(1'b1, 16'hFFFF, 24'hFFFFFF);

      // capacity 5: climb to the alarm, tail drop, drain to idle
      write_capacity(8'd5);
      for (int i = 0; i < 7; i++) offer_item(1'b0, TAG_W'(16'hA000 + i), DUR_W'(24'h5000 + i));
      repeat (7) offer_item(1'b1, '0, '0);
      // relief into an empty queue, then the data packet behind it
      offer_item(1'b0, 16'h5A5A, 24'hA5A5A5);
      offer_item(1'b1, '0, '0);

      // capacity zero drops every arrival
      write_capacity(8'd0);
      offer_item(1'b0, 16'h1234, 24'h123456);
      offer_item(1'b0, 16'hFFFF, 24'hFFFFFF);
      offer_item(1'b1, '0, '0);

      // random phases
      write_capacity(8'd8);
      random_items(80);

      write_capacity(8'd1);
      steady = 1'b1;
      random_items(40);
      steady = 1'b0;

      // long receiver hold fills the block, then a full pause of the sender
      write_capacity(8'd30);
      random_items(20);
      hold_request = 300;
      random_items(50);
      drain_outstanding();
      random_items(50);

      mid_cap = CAP_W'($urandom_range(2, 60));
      write_capacity(mid_cap);
      random_items(70);

      write_capacity(8'd255);
      random_items(320);

      drain_outstanding();
      $display("ran %0d items, %0d result beats checked, capacities 200 5 0 8 1 30 %0d 255",
               shadow.items, shadow.beats, mid_cap);
      $display("seen: %0d drops, %0d alarms, %0d reliefs, %0d idle results, %0d mismatches",
               shadow.drops, shadow.alarms, shadow.reliefs, shadow.idles, shadow.mismatches);
      if (shadow.mismatches == 0)
         $display("tail_drop_queue_with_watermark_feedback_top_tb passed");
      else
         $display("tail_drop_queue_with_watermark_feedback_top_tb failed");
      $finish;
   end

endmodule
